### rtl/core/cjre_pkg.sv
// ----------------------------------------------------------------------------
// cjre_pkg
// Shared types, codes and defaults of the cookie jar request engine.
// ----------------------------------------------------------------------------
package cjre_pkg;

   // Fixed field widths of the request and result items.
   localparam int KIND_W         = 3;
   localparam int STATUS_W       = 2;
   localparam int COOKIE_FIELD_W = 64;

   // Default sizes handed to the top level.
   localparam int DEF_COOKIE_BYTES = 8;
   localparam int DEF_CLIENT_DEPTH = 16;
   localparam int DEF_SERVER_DEPTH = 16;

   // Request kinds; the remaining codes are bad requests.
   typedef enum logic [KIND_W-1:0] {
      KIND_CLIENT_INSERT   = 3'd0,
      KIND_CLIENT_RETRIEVE = 3'd1,
      KIND_SERVER_INSERT   = 3'd2,
      KIND_SERVER_VERIFY   = 3'd3
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FAIL = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_BAD  = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_POP,
      STATE_SCAN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       c_push;
      logic       c_pop;
      logic       s_push;
      logic       sv_start;
      logic       sv_step;
      logic       sv_finish;
      logic       load;
      logic       load_pop;
      status_type load_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic c_empty;
      logic c_full;
      logic s_full;
      logic scan_done;
      logic hit;
      logic out_free;
   } stat_type;

endpackage

### rtl/core/cjre_if.sv
// ----------------------------------------------------------------------------
// cjre_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cjre_req_if
   import cjre_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [COOKIE_FIELD_W-1:0] cookie_value;

   modport source (output valid, kind, cookie_value, input ready);
   modport sink   (input valid, kind, cookie_value, output ready);
endinterface

interface cjre_rsp_if
   import cjre_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [COOKIE_FIELD_W-1:0] cookie_out;

   modport source (output valid, status, cookie_out, input ready);
   modport sink   (input valid, status, cookie_out, output ready);
endinterface

### rtl/core/cjre_ram.sv
// ----------------------------------------------------------------------------
// cjre_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cjre_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read with the data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cjre_datapath.sv
// ----------------------------------------------------------------------------
// cjre_datapath
// Client stack, server table, scan pointers and the result register.
// ----------------------------------------------------------------------------
module cjre_datapath
   import cjre_pkg::*;
#(
   parameter int COOKIE_BYTES = DEF_COOKIE_BYTES,
   parameter int CLIENT_DEPTH = DEF_CLIENT_DEPTH,
   parameter int SERVER_DEPTH = DEF_SERVER_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [COOKIE_FIELD_W-1:0] req_cookie,
   input  logic                      rsp_ready,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COOKIE_FIELD_W-1:0] rsp_cookie
);

   localparam int CK_W = 8 * COOKIE_BYTES;
   localparam int C_AW = (CLIENT_DEPTH > 1) ? $clog2(CLIENT_DEPTH) : 1;
   localparam int C_CW = $clog2(CLIENT_DEPTH + 1);
   localparam int S_AW = (SERVER_DEPTH > 1) ? $clog2(SERVER_DEPTH) : 1;
   localparam int S_CW = $clog2(SERVER_DEPTH + 1);

   logic [CK_W-1:0]           ck_req;
   logic [CK_W-1:0]           ck_ff, ck_in;
   logic [C_CW-1:0]           c_count_ff, c_count_in;
   logic [C_CW-1:0]           c_top;
   logic [CK_W-1:0]           c_rd_data;
   logic [S_CW-1:0]           s_count_ff, s_count_in;
   logic [S_CW-1:0]           rd_ff, rd_in;
   logic [S_CW-1:0]           wr_ff, wr_in;
   logic                      pend_ff, pend_in;
   logic                      hit_ff, hit_in;
   logic [CK_W-1:0]           s_rd_data;
   logic                      match;
   logic                      s_we;
   logic [S_CW-1:0]           s_waddr;
   logic [CK_W-1:0]           s_wdata;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [COOKIE_FIELD_W-1:0] rsp_cookie_ff, rsp_cookie_in;

   // Bits above the cookie width take no part in anything.
   assign ck_req = req_cookie[CK_W-1:0];

   // Client stack: push at the count, pop reads the entry below it.
   assign c_top = c_count_ff - 1'b1;

   cjre_ram #(
      .WIDTH (CK_W),
      .DEPTH (CLIENT_DEPTH)
   ) u_client_ram (
      .clock   (clock),
      .wr_en   (cmd.c_push),
      .wr_addr (c_count_ff[C_AW-1:0]),
      .wr_data (ck_req),
      .rd_addr (c_top[C_AW-1:0]),
      .rd_data (c_rd_data)
   );

   // Server table: insert appends; the scan writes survivors back in order.
   assign match   = (s_rd_data == ck_ff);
   assign s_we    = cmd.s_push | (cmd.sv_step & pend_ff & ~match);
   assign s_waddr = cmd.s_push ? s_count_ff : wr_ff;
   assign s_wdata = cmd.s_push ? ck_req : s_rd_data;

   cjre_ram #(
      .WIDTH (CK_W),
      .DEPTH (SERVER_DEPTH)
   ) u_server_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr[S_AW-1:0]),
      .wr_data (s_wdata),
      .rd_addr (rd_ff[S_AW-1:0]),
      .rd_data (s_rd_data)
   );

   // Counts, scan pointers and the verify cookie.
   always_comb begin
      c_count_in = c_count_ff;
      s_count_in = s_count_ff;
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      pend_in    = pend_ff;
      hit_in     = hit_ff;
      ck_in      = ck_ff;
      if (cmd.c_push) begin
         c_count_in = c_count_ff + 1'b1;
      end
      if (cmd.c_pop) begin
         c_count_in = c_top;
      end
      if (cmd.s_push) begin
         s_count_in = s_count_ff + 1'b1;
      end
      if (cmd.sv_start) begin
         ck_in   = ck_req;
         rd_in   = '0;
         wr_in   = '0;
         pend_in = 1'b0;
         hit_in  = 1'b0;
      end
      if (cmd.sv_step) begin
         // Issue the next read while entries remain.
         if (rd_ff != s_count_ff) begin
            rd_in   = rd_ff + 1'b1;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         // Judge the entry read in the previous cycle.
         if (pend_ff) begin
            if (match) begin
               hit_in = 1'b1;
            end else begin
               wr_in = wr_ff + 1'b1;
            end
         end
      end
      if (cmd.sv_finish) begin
         s_count_in = wr_ff;
      end
   end

   // Result register: a new item may load while the old one is taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_cookie_in = rsp_cookie_ff;
      if (cmd.load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.load_status;
         rsp_cookie_in = cmd.load_pop ? COOKIE_FIELD_W'(c_rd_data) : '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_count_ff   <= '0;
         s_count_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c_count_ff   <= c_count_in;
         s_count_ff   <= s_count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ck_ff         <= ck_in;
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cookie_ff <= rsp_cookie_in;
   end

   // Status to the controller.
   assign stat.c_empty   = (c_count_ff == '0);
   assign stat.c_full    = (c_count_ff == C_CW'(CLIENT_DEPTH));
   assign stat.s_full    = (s_count_ff == S_CW'(SERVER_DEPTH));
   assign stat.scan_done = (rd_ff == s_count_ff) & ~pend_ff;
   assign stat.hit       = hit_ff;
   assign stat.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_cookie = rsp_cookie_ff;

endmodule

### rtl/core/cjre_ctrl.sv
// ----------------------------------------------------------------------------
// cjre_ctrl
// Request sequencer: decodes each item and steps the datapath through it.
// ----------------------------------------------------------------------------
module cjre_ctrl
   import cjre_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   input  stat_type          stat,
   output logic              req_ready,
   output cmd_type           cmd
);

   state_type state_ff, state_in;
   logic      accept;

   // An item enters only when idle and the result register can take its answer.
   assign req_ready = (state_ff == STATE_IDLE) & stat.out_free;
   assign accept    = req_valid & req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_CLIENT_RETRIEVE: begin
                     if (!stat.c_empty) begin
                        state_in = STATE_POP;
                     end
                  end
                  KIND_SERVER_VERIFY: state_in = STATE_SCAN;
                  default:            state_in = STATE_IDLE;
               endcase
            end
         end
         STATE_POP:  state_in = STATE_IDLE;
         STATE_SCAN: begin
            if (stat.scan_done) begin
               state_in = STATE_IDLE;
            end
         end
         default:    state_in = STATE_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd             = '0;
      cmd.load_status = STATUS_BAD;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_CLIENT_INSERT: begin
                     cmd.load = 1'b1;
                     if (stat.c_full) begin
                        cmd.load_status = STATUS_FULL;
                     end else begin
                        cmd.c_push      = 1'b1;
                        cmd.load_status = STATUS_OK;
                     end
                  end
                  KIND_CLIENT_RETRIEVE: begin
                     if (stat.c_empty) begin
                        cmd.load        = 1'b1;
                        cmd.load_status = STATUS_FAIL;
                     end else begin
                        cmd.c_pop = 1'b1;
                     end
                  end
                  KIND_SERVER_INSERT: begin
                     cmd.load = 1'b1;
                     if (stat.s_full) begin
                        cmd.load_status = STATUS_FULL;
                     end else begin
                        cmd.s_push      = 1'b1;
                        cmd.load_status = STATUS_OK;
                     end
                  end
                  KIND_SERVER_VERIFY: begin
                     cmd.sv_start = 1'b1;
                  end
                  default: begin
                     cmd.load        = 1'b1;
                     cmd.load_status = STATUS_BAD;
                  end
               endcase
            end
         end
         STATE_POP: begin
            // The popped entry is on the read port now.
            cmd.load        = 1'b1;
            cmd.load_pop    = 1'b1;
            cmd.load_status = STATUS_OK;
         end
         STATE_SCAN: begin
            if (stat.scan_done) begin
               cmd.sv_finish   = 1'b1;
               cmd.load        = 1'b1;
               cmd.load_status = stat.hit ? STATUS_OK : STATUS_FAIL;
            end else begin
               cmd.sv_step = 1'b1;
            end
         end
         default: begin
            cmd.load_status = STATUS_BAD;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/cookie_jar_request_engine.sv
// ----------------------------------------------------------------------------
// cookie_jar_request_engine
// Serves cookie requests against a client stack and a server table.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+--------------------------------
//  req_chan  | in        | kind, cookie_value
//  rsp_chan  | out       | status, cookie_out
//
// Inserts, bad requests and a retrieve from an empty stack load their result as they
// are accepted; any other retrieve first makes one registered read of the stack memory.
// A verify scans the server table, reading and rewriting it one entry a cycle through
// its one read port and its one write port.
// Reset empties both stores at once; their memories need no clearing.
// An item is taken only when the block is idle and no result waits, or it leaves.
// ----------------------------------------------------------------------------
module cookie_jar_request_engine
   import cjre_pkg::*;
#(
   parameter int COOKIE_BYTES = DEF_COOKIE_BYTES,
   parameter int CLIENT_DEPTH = DEF_CLIENT_DEPTH,
   parameter int SERVER_DEPTH = DEF_SERVER_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   cjre_req_if.sink    req_chan,
   cjre_rsp_if.source  rsp_chan
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   cjre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   cjre_datapath #(
      .COOKIE_BYTES (COOKIE_BYTES),
      .CLIENT_DEPTH (CLIENT_DEPTH),
      .SERVER_DEPTH (SERVER_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_cookie (req_chan.cookie_value),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_chan.valid),
      .rsp_status (rsp_chan.status),
      .rsp_cookie (rsp_chan.cookie_out)
   );

   assign req_chan.ready = req_ready;

endmodule
